>>> hdl/spa_pkg.sv
package spa_pkg;

  // Pool geometry
  localparam int SLOTS      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);

  // Request opcodes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  slot_index;
    logic [31:0] entry_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_index;
    logic [31:0] read_data;
    logic [8:0]  live_count;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, launch memory reads
    logic exec;     // resolve request, update pool, load result
  } cmd_t;

endpackage

>>> hdl/spa_ctrl.sv
module spa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output spa_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Commands are decoded combinationally from the state and start
  always_comb begin
    cmd.capture = start && (state == S_IDLE);
    cmd.exec    = (state == S_EXEC);
    busy        = (state != S_IDLE);
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/spa_datapath.sv
module spa_datapath (
  input  logic          clk,
  input  logic          rst,
  input  spa_pkg::cmd_t cmd,
  input  spa_pkg::req_t request,
  output spa_pkg::rsp_t result
);

  localparam int IW = spa_pkg::IDX_W;
  localparam int CW = spa_pkg::CNT_W;
  localparam int DW = spa_pkg::DATA_WIDTH;
  localparam int N  = spa_pkg::SLOTS;

  // Memories
  logic [IW-1:0] avail_stack [N];
  logic [DW-1:0] entry_store [N];

  // Control state
  logic [CW-1:0] stack_top;
  logic [N-1:0]  occupied;
  logic [N-1:0]  stack_written;  // stack entry overwritten since reset

  // Captured request and registered reads
  spa_pkg::req_t req;
  logic [IW-1:0] pop_pos;
  logic [IW-1:0] stack_rd;
  logic          stack_rd_written;
  logic [DW-1:0] store_rd;

  logic [IW-1:0] rd_pos;
  logic [IW-1:0] req_slot;
  logic [IW-1:0] popped;
  logic          idx_valid;
  logic          pool_empty;
  logic          do_pop;
  logic          do_push;
  logic [CW-1:0] stack_top_next;
  spa_pkg::rsp_t rsp_next;

  assign rd_pos   = IW'(stack_top - CW'(1));
  assign req_slot = IW'(req.slot_index);
  assign popped   = stack_rd_written ? stack_rd : pop_pos;

  // Resolve the captured request
  always_comb begin
    idx_valid  = ({1'b0, req.slot_index} < 9'(N)) && occupied[req_slot];
    pool_empty = (stack_top == '0) || (stack_top > CW'(N));
    do_pop     = 1'b0;
    do_push    = 1'b0;
    rsp_next.status        = spa_pkg::ST_OK;
    rsp_next.granted_index = req.slot_index;
    rsp_next.read_data     = '0;
    case (req.opcode)
      spa_pkg::OP_ALLOC: begin
        if (pool_empty) begin
          rsp_next.status        = spa_pkg::ST_FULL;
          rsp_next.granted_index = '0;
        end else begin
          do_pop                 = 1'b1;
          rsp_next.granted_index = 8'(popped);
        end
      end
      spa_pkg::OP_FREE: begin
        if (!idx_valid || stack_top >= CW'(N)) rsp_next.status = spa_pkg::ST_EMPTY;
        else do_push = 1'b1;
      end
      spa_pkg::OP_READ: begin
        if (!idx_valid) rsp_next.status = spa_pkg::ST_EMPTY;
        else rsp_next.read_data = 32'(store_rd);
      end
      default: rsp_next.status = spa_pkg::ST_EMPTY;
    endcase
    stack_top_next = stack_top;
    if (do_pop) stack_top_next = stack_top - CW'(1);
    else if (do_push) stack_top_next = stack_top + CW'(1);
    rsp_next.live_count = 9'(CW'(N) - stack_top_next);
  end

  // Memory ports: reads on capture, writes on exec
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stack_rd <= avail_stack[rd_pos];
      store_rd <= entry_store[IW'(request.slot_index)];
    end
    if (cmd.exec && do_push) avail_stack[IW'(stack_top)] <= req_slot;
    if (cmd.exec && do_pop) entry_store[popped] <= DW'(req.entry_data);
  end

  // Request capture and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req              <= request;
      pop_pos          <= rd_pos;
      stack_rd_written <= stack_written[rd_pos];
    end
    if (cmd.exec) result <= rsp_next;
  end

  // Pool control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top     <= CW'(N);
      occupied      <= '0;
      stack_written <= '0;
    end else if (cmd.exec) begin
      stack_top <= stack_top_next;
      if (do_pop) occupied[popped] <= 1'b1;
      if (do_push) begin
        occupied[req_slot]                <= 1'b0;
        stack_written[IW'(stack_top)] <= 1'b1;
      end
    end
  end

endmodule

>>> hdl/slot_pool_allocator.sv
// Slot pool allocator: a fixed pool of slots handed out from a free-index stack.
// Request channel: drive request (opcode, slot_index, entry_data) and raise
// start; the request is taken at a clock edge where start is high and busy low.
// Opcodes: allocate pops a free slot and stores entry_data there; free
// returns an occupied slot to the stack; read returns the stored data.
// Result channel: done pulses for one cycle with result (status,
// granted_index, read_data, live_count) valid in that cycle. The receiver
// cannot stall; each result must be taken in the cycle it is shown.
// Timing: the request and the stack and data memory reads are registered at
// the accepting edge; the result and done are registered from them in the
// resolve/update state. A new request is not taken while busy: the registered
// read of the stack and data memories is followed by the resolve/update state.
// Reset: synchronous; the stack holds slot indices 0..SLOTS-1 in order, no slot
// is occupied, and the first allocation hands out the highest slot. Reset
// takes effect at once, with no clearing pass; stored data is undefined
// until a slot is allocated.
module slot_pool_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  spa_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output spa_pkg::rsp_t result
);

  spa_pkg::cmd_t cmd;

  spa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  spa_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .result  (result)
  );

endmodule
